### rtl/ccfv_pkg.sv
// ccfv_pkg: shared types, constants and the command bounds table of the
// can command frame validator. No dependencies.
`default_nettype none

package ccfv_pkg;

    // field widths
    localparam int unsigned FRAME_ID_W   = 29;
    localparam int unsigned SHORT_ID_W   = 11;
    localparam int unsigned FRAME_LEN_W  = 7;
    localparam int unsigned CMD_W        = 8;
    localparam int unsigned PAYLOAD_W    = 6;
    localparam int unsigned VERDICT_W    = 3;
    localparam int unsigned SLOT_IDX_W   = 3;
    localparam int unsigned BOUND_W      = 4;

    // handler slots
    localparam int unsigned HANDLER_SLOTS = 8;
    localparam int unsigned SLOT_CNT_W    = 4;

    // frame limits
    localparam logic [FRAME_LEN_W-1:0] MAX_FRAME_LEN  = 7'd64;
    localparam logic [CMD_W-1:0]       FIRST_KNOWN_CMD = 8'h01;
    localparam logic [CMD_W-1:0]       LAST_KNOWN_CMD  = 8'h13;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_ID_FILTER     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_MASK       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COMMANDS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_PRESENT  = 3'd4;

    typedef enum logic [VERDICT_W-1:0] {
        V_ACCEPT       = 3'd0,
        V_ID_MISMATCH  = 3'd1,
        V_BAD_LENGTH   = 3'd2,
        V_UNKNOWN_CMD  = 3'd3,
        V_PAYLOAD_OOB  = 3'd4,
        V_NO_HANDLER   = 3'd5
    } t_verdict;

    typedef struct packed {
        logic [SHORT_ID_W-1:0]          id_filter;
        logic [SHORT_ID_W-1:0]          id_mask;
        logic [HANDLER_SLOTS*CMD_W-1:0] slot_commands;
        logic [SLOT_CNT_W-1:0]          slot_count;
        logic [HANDLER_SLOTS-1:0]       slot_present;
    } t_cfg;

    typedef struct packed {
        logic [SHORT_ID_W-1:0]  short_id;
        logic [FRAME_LEN_W-1:0] frame_length;
        logic [CMD_W-1:0]       command_code;
    } t_frame;

    typedef struct packed {
        t_verdict               verdict;
        logic [SLOT_IDX_W-1:0]  slot_index;
        logic [CMD_W-1:0]       command_code;
        logic [PAYLOAD_W-1:0]   payload_length;
        logic [SHORT_ID_W-1:0]  short_id;
    } t_result;

    typedef struct packed {
        logic [BOUND_W-1:0] min_len;
        logic [BOUND_W-1:0] max_len;
    } t_bounds;

    // payload length bounds per known command
    function automatic t_bounds cmd_bounds(input logic [CMD_W-1:0] cmd);
        t_bounds b;
        case (cmd)
            8'h01, 8'h03, 8'h11: b = '{min_len: 4'd4,  max_len: 4'd4};
            8'h04:               b = '{min_len: 4'd12, max_len: 4'd15};
            8'h02, 8'h05, 8'h06,
            8'h0C:               b = '{min_len: 4'd2,  max_len: 4'd2};
            8'h0D:               b = '{min_len: 4'd0,  max_len: 4'd0};
            8'h0E:               b = '{min_len: 4'd11, max_len: 4'd11};
            8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0F, 8'h10, 8'h12,
            8'h13:               b = '{min_len: 4'd1,  max_len: 4'd1};
            default:             b = '{min_len: 4'd0,  max_len: 4'd0};
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### rtl/ccfv_if.sv
// ccfv_in_if and ccfv_out_if: valid/ready channels for frame headers and
// verdicts. Depends on ccfv_pkg.
`default_nettype none

interface ccfv_in_if import ccfv_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [FRAME_ID_W-1:0]  frame_id;
    logic [FRAME_LEN_W-1:0] frame_length;
    logic [CMD_W-1:0]       first_byte;

    modport source (output valid, frame_id, frame_length, first_byte, input ready);
    modport sink   (input valid, frame_id, frame_length, first_byte, output ready);
endinterface

interface ccfv_out_if import ccfv_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [VERDICT_W-1:0]  verdict;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [CMD_W-1:0]      command_code;
    logic [PAYLOAD_W-1:0]  payload_length;
    logic [SHORT_ID_W-1:0] short_id;

    modport source (output valid, verdict, slot_index, command_code, payload_length,
                    short_id, input ready);
    modport sink   (input valid, verdict, slot_index, command_code, payload_length,
                    short_id, output ready);
endinterface

`default_nettype wire

### rtl/ccfv_cfg_regs.sv
// ccfv_cfg_regs: configuration register file written through a plain
// write port. Depends on ccfv_pkg.
`default_nettype none

module ccfv_cfg_regs import ccfv_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // register decode, unknown indexes leave everything as it is
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ID_FILTER:     n_cfg.id_filter     = i_cfg_data[SHORT_ID_W-1:0];
                CFG_ID_MASK:       n_cfg.id_mask       = i_cfg_data[SHORT_ID_W-1:0];
                CFG_SLOT_COMMANDS: n_cfg.slot_commands = i_cfg_data[HANDLER_SLOTS*CMD_W-1:0];
                CFG_SLOT_COUNT:    n_cfg.slot_count    = i_cfg_data[SLOT_CNT_W-1:0];
                CFG_SLOT_PRESENT:  n_cfg.slot_present  = i_cfg_data[HANDLER_SLOTS-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    // all registers reset to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/ccfv_judge.sv
// ccfv_judge: combinational checks of one registered frame header against
// the configuration. Depends on ccfv_pkg.
`default_nettype none

module ccfv_judge import ccfv_pkg::*; (
    input  wire t_frame i_frame,
    input  wire t_cfg   i_cfg,
    output t_result     o_result
);

    logic                     len_ok;
    logic                     id_ok;
    logic                     cmd_known;
    logic                     bounds_ok;
    logic [PAYLOAD_W-1:0]     payload;
    t_bounds                  bounds;
    logic [SLOT_CNT_W-1:0]    limit;
    logic [HANDLER_SLOTS-1:0] hit;
    logic                     found;
    logic [SLOT_IDX_W-1:0]    hit_idx;
    t_result                  res;

    // header checks
    always_comb begin
        id_ok     = (i_frame.short_id & i_cfg.id_mask) == (i_cfg.id_filter & i_cfg.id_mask);
        len_ok    = (i_frame.frame_length != '0) && (i_frame.frame_length <= MAX_FRAME_LEN);
        payload   = len_ok ? PAYLOAD_W'(i_frame.frame_length - FRAME_LEN_W'(1)) : '0;
        cmd_known = (i_frame.command_code >= FIRST_KNOWN_CMD)
                    && (i_frame.command_code <= LAST_KNOWN_CMD);
        bounds    = cmd_bounds(i_frame.command_code);
        bounds_ok = (payload >= PAYLOAD_W'(bounds.min_len))
                    && (payload <= PAYLOAD_W'(bounds.max_len));
    end

    // slot lanes: compare every slot, then pick the lowest hit
    always_comb begin
        limit = (i_cfg.slot_count > SLOT_CNT_W'(HANDLER_SLOTS))
                ? SLOT_CNT_W'(HANDLER_SLOTS) : i_cfg.slot_count;
        for (int k = 0; k < HANDLER_SLOTS; k++) begin
            hit[k] = (i_cfg.slot_commands[k*CMD_W +: CMD_W] == i_frame.command_code)
                     && (SLOT_CNT_W'(k) < limit);
        end
        found   = |hit;
        hit_idx = '0;
        for (int k = HANDLER_SLOTS - 1; k >= 0; k--) begin
            if (hit[k]) begin
                hit_idx = SLOT_IDX_W'(k);
            end
        end
    end

    // verdict in check order, first failure wins
    always_comb begin
        res.slot_index     = '0;
        res.command_code   = i_frame.command_code;
        res.payload_length = payload;
        res.short_id       = i_frame.short_id;
        if (!id_ok) begin
            res.verdict = V_ID_MISMATCH;
        end else if (!len_ok) begin
            res.verdict = V_BAD_LENGTH;
        end else if (!cmd_known) begin
            res.verdict = V_UNKNOWN_CMD;
        end else if (!bounds_ok) begin
            res.verdict = V_PAYLOAD_OOB;
        end else if (found && i_cfg.slot_present[hit_idx]) begin
            res.verdict    = V_ACCEPT;
            res.slot_index = hit_idx;
        end else begin
            res.verdict = V_NO_HANDLER;
        end
    end

    assign o_result = res;

endmodule

`default_nettype wire

### rtl/can_command_frame_validator_unit.sv
// can_command_frame_validator_unit: top level, input register, checks and
// result register. Depends on ccfv_pkg, ccfv_if, ccfv_cfg_regs, ccfv_judge.
//
//   channel   dir   handshake          contents
//   i_in      in    valid/ready        frame_id, frame_length, first_byte
//   o_out     out   valid/ready        verdict, slot_index, command_code,
//                                      payload_length, short_id
//   i_cfg_*   in    write enable only  register index, write data
//
// One frame per cycle while the verdict sink keeps ready high; the frame goes
// into the input register at the edge that takes it, and its verdict is then
// loaded into the result register, from which it is offered.
// Input ready only falls when both the input register and the result
// register hold items and the result is not being taken.
// Synchronous active-low reset empties both stages and zeroes the configuration registers.
`default_nettype none

module can_command_frame_validator_unit import ccfv_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    ccfv_in_if.sink                    i_in,
    ccfv_out_if.source                 o_out,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    w_cfg;
    t_result w_res;

    logic    r_s1_valid;
    logic    n_s1_valid;
    t_frame  r_s1;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_res;

    logic    s1_ready;
    logic    s2_ready;
    logic    s1_load;
    logic    s2_load;

    ccfv_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    ccfv_judge u_judge (
        .i_frame  (r_s1),
        .i_cfg    (w_cfg),
        .o_result (w_res)
    );

    // pipeline flow control
    always_comb begin
        s2_ready    = !r_out_valid || o_out.ready;
        s1_ready    = !r_s1_valid || s2_ready;
        s1_load     = i_in.valid && s1_ready;
        s2_load     = r_s1_valid && s2_ready;
        n_s1_valid  = s1_ready ? i_in.valid : r_s1_valid;
        n_out_valid = s2_ready ? r_s1_valid : r_out_valid;
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1.short_id     <= i_in.frame_id[SHORT_ID_W-1:0];
            r_s1.frame_length <= i_in.frame_length;
            r_s1.command_code <= i_in.first_byte;
        end
        if (s2_load) begin
            r_res <= w_res;
        end
    end

    assign i_in.ready           = s1_ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.verdict        = r_res.verdict;
    assign o_out.slot_index     = r_res.slot_index;
    assign o_out.command_code   = r_res.command_code;
    assign o_out.payload_length = r_res.payload_length;
    assign o_out.short_id       = r_res.short_id;

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

    // an accepted verdict names a slot that is present and in use
    a_accept_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_res.verdict == V_ACCEPT) |->
            (w_cfg.slot_present[w_res.slot_index]
             && SLOT_CNT_W'(w_res.slot_index) < w_cfg.slot_count))
        else $error("accept without a present slot in range");

    // slot index is zero unless accepted
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_res.verdict != V_ACCEPT) |-> (w_res.slot_index == '0))
        else $error("slot index set on a rejected frame");

    // a bad length reports no payload
    a_bad_len_pay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_res.verdict == V_BAD_LENGTH) |-> (w_res.payload_length == '0))
        else $error("payload length on a bad length frame");

    // a held frame in the input register is not dropped
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_ready) |=> r_s1_valid)
        else $error("stalled frame lost");

endmodule

`default_nettype wire

### bench/tb.sv
// tb: self-checking bench for can_command_frame_validator_unit, directed table
// then random register settings with bursty frames and a stalling verdict sink.
// Depends on ccfv_pkg, ccfv_if and the validator rtl.
module tb import ccfv_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // spare register indexes, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // command codes used by the bench, most with payload bounds other than a single byte
    localparam logic [CMD_W-1:0] CMD_QUAD      = 8'h01;
    localparam logic [CMD_W-1:0] CMD_PAIR      = 8'h02;
    localparam logic [CMD_W-1:0] CMD_QUAD_B    = 8'h03;
    localparam logic [CMD_W-1:0] CMD_LONG      = 8'h04;
    localparam logic [CMD_W-1:0] CMD_PAIR_B    = 8'h05;
    localparam logic [CMD_W-1:0] CMD_PAIR_C    = 8'h06;
    localparam logic [CMD_W-1:0] CMD_SINGLE    = 8'h07;
    localparam logic [CMD_W-1:0] CMD_PAIR_D    = 8'h0C;
    localparam logic [CMD_W-1:0] CMD_EMPTY     = 8'h0D;
    localparam logic [CMD_W-1:0] CMD_ELEVEN    = 8'h0E;
    localparam logic [CMD_W-1:0] CMD_QUAD_C    = 8'h11;
    localparam logic [CMD_W-1:0] CMD_PAST_LAST = LAST_KNOWN_CMD + 8'h01;

    localparam int RUN_LIMIT       = 200000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 6;
    localparam int MAX_REPORTS     = 10;

    typedef enum {ROW_CFG, ROW_FRAME} t_row_kind;
    typedef enum {RX_STEADY, RX_COIN, RX_EVERY_THIRD, RX_SPARSE} t_rx_mode;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [FRAME_ID_W-1:0]  id;
        logic [FRAME_LEN_W-1:0] len;
        logic [CMD_W-1:0]       cmd;
        bit                     typed;
        t_verdict               v;
        logic [SLOT_IDX_W-1:0]  slot;
    } t_dir_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ccfv_in_if  in_ch ();
    ccfv_out_if out_ch ();

    can_command_frame_validator_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // shadow copy of the filter and handler registers
    logic [SHORT_ID_W-1:0]          sh_filter  = '0;
    logic [SHORT_ID_W-1:0]          sh_mask    = '0;
    logic [HANDLER_SLOTS*CMD_W-1:0] sh_cmds    = '0;
    logic [SLOT_CNT_W-1:0]          sh_count   = '0;
    logic [HANDLER_SLOTS-1:0]       sh_present = '0;

    // typed-in verdict riding along with the frame on offer
    logic                  pin_on;
    t_verdict              pin_verdict;
    logic [SLOT_IDX_W-1:0] pin_slot;

    t_result  verdicts_due[$];
    t_dir_row dir_rows[$];

    int frames_taken  = 0;
    int verdicts_seen = 0;
    int faults        = 0;
    int cfg_writes    = 0;
    int burst_left    = 0;
    int run_cycles    = 0;
    int hold_seq      = 0;
    int vcount[8];

    // payload bounds of a command, known is low for codes outside the set
    function automatic void payload_window(input logic [CMD_W-1:0] cmd, output bit known,
                                           output int lo, output int hi);
        known = 1'b1;
        case (cmd)
            CMD_QUAD, CMD_QUAD_B, CMD_QUAD_C: begin lo = 4; hi = 4; end
            CMD_LONG: begin lo = 12; hi = 15; end
            CMD_PAIR, CMD_PAIR_B, CMD_PAIR_C, CMD_PAIR_D: begin lo = 2; hi = 2; end
            CMD_EMPTY: begin lo = 0; hi = 0; end
            CMD_ELEVEN: begin lo = 11; hi = 11; end
            default: begin
                lo = 1;
                hi = 1;
                if (cmd < FIRST_KNOWN_CMD || cmd > LAST_KNOWN_CMD) begin
                    known = 1'b0;
                    lo = 0;
                    hi = 0;
                end
            end
        endcase
    endfunction

    // verdict for one frame header under the shadow registers
    function automatic t_result judge_frame(input logic [FRAME_ID_W-1:0] id,
                                            input logic [FRAME_LEN_W-1:0] len,
                                            input logic [CMD_W-1:0] cmd);
        t_result r;
        bit      known;
        bit      found;
        bit      len_ok;
        int      lo;
        int      hi;
        int      limit;
        int      hit;
        r.short_id       = id[SHORT_ID_W-1:0];
        r.command_code   = cmd;
        r.slot_index     = '0;
        len_ok           = (len >= 7'd1) && (len <= MAX_FRAME_LEN);
        r.payload_length = len_ok ? PAYLOAD_W'(len - 7'd1) : '0;
        payload_window(cmd, known, lo, hi);
        if ((r.short_id & sh_mask) != (sh_filter & sh_mask)) begin
            r.verdict = V_ID_MISMATCH;
        end else if (!len_ok) begin
            r.verdict = V_BAD_LENGTH;
        end else if (!known) begin
            r.verdict = V_UNKNOWN_CMD;
        end else if (int'(r.payload_length) < lo || int'(r.payload_length) > hi) begin
            r.verdict = V_PAYLOAD_OOB;
        end else begin
            // only the lowest matching slot counts
            limit = (sh_count > HANDLER_SLOTS) ? HANDLER_SLOTS : int'(sh_count);
            found = 1'b0;
            hit   = 0;
            for (int k = 0; k < limit; k++) begin
                if (!found && sh_cmds[8*k +: 8] == cmd) begin
                    found = 1'b1;
                    hit   = k;
                end
            end
            if (found && sh_present[hit]) begin
                r.verdict    = V_ACCEPT;
                r.slot_index = SLOT_IDX_W'(hit);
            end else begin
                r.verdict = V_NO_HANDLER;
            end
        end
        return r;
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        t_dir_row r;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.data  = data;
        r.id    = '0;
        r.len   = '0;
        r.cmd   = '0;
        r.typed = 1'b0;
        r.v     = V_ACCEPT;
        r.slot  = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_frame(input logic [FRAME_ID_W-1:0] id,
                                      input logic [FRAME_LEN_W-1:0] len,
                                      input logic [CMD_W-1:0] cmd, input bit typed,
                                      input t_verdict v, input logic [SLOT_IDX_W-1:0] slot);
        t_dir_row r;
        r.kind  = ROW_FRAME;
        r.idx   = '0;
        r.data  = '0;
        r.id    = id;
        r.len   = len;
        r.cmd   = cmd;
        r.typed = typed;
        r.v     = v;
        r.slot  = slot;
        dir_rows.push_back(r);
    endfunction

    // offer one frame header, bursts of random length with random gaps
    task automatic send_frame(input logic [FRAME_ID_W-1:0] id,
                              input logic [FRAME_LEN_W-1:0] len,
                              input logic [CMD_W-1:0] cmd, input bit typed, input t_verdict v,
                              input logic [SLOT_IDX_W-1:0] slot);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 5);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_ch.valid        <= 1'b1;
        in_ch.frame_id     <= id;
        in_ch.frame_length <= len;
        in_ch.first_byte   <= cmd;
        pin_on             <= typed;
        pin_verdict        <= v;
        pin_slot           <= slot;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
    endtask

    // stop offering and wait until every verdict is back
    task automatic drain(input int extra);
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (verdicts_due.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    // one register write, shadow follows the same field widths
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_ID_FILTER:     sh_filter  = data[SHORT_ID_W-1:0];
            CFG_ID_MASK:       sh_mask    = data[SHORT_ID_W-1:0];
            CFG_SLOT_COMMANDS: sh_cmds    = data;
            CFG_SLOT_COUNT:    sh_count   = data[SLOT_CNT_W-1:0];
            CFG_SLOT_PRESENT:  sh_present = data[HANDLER_SLOTS-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // register setting per random phase, first phases pinned to the extremes
    task automatic random_config(input int p);
        logic [SHORT_ID_W-1:0]          filt;
        logic [SHORT_ID_W-1:0]          msk;
        logic [HANDLER_SLOTS*CMD_W-1:0] cmds;
        logic [SLOT_CNT_W-1:0]          cnt;
        logic [HANDLER_SLOTS-1:0]       pres;
        filt = SHORT_ID_W'($urandom_range(0, 2047));
        case ($urandom_range(0, 3))
            0:       msk = '0;
            1:       msk = '1;
            default: msk = SHORT_ID_W'($urandom_range(0, 2047));
        endcase
        for (int k = 0; k < HANDLER_SLOTS; k++) begin
            if ($urandom_range(0, 9) < 8)
                cmds[8*k +: 8] = CMD_W'($urandom_range(FIRST_KNOWN_CMD, LAST_KNOWN_CMD));
            else
                cmds[8*k +: 8] = CMD_W'($urandom_range(0, 255));
        end
        case ($urandom_range(0, 3))
            0:       cnt = SLOT_CNT_W'(HANDLER_SLOTS);
            1:       cnt = '1;
            default: cnt = SLOT_CNT_W'($urandom_range(0, 15));
        endcase
        pres = ($urandom_range(0, 2) == 0) ? '1 : HANDLER_SLOTS'($urandom_range(0, 255));
        case (p)
            0: begin
                filt = '0;
                msk  = '0;
                cmds = '0;
                cnt  = '0;
                pres = '0;
            end
            1: begin
                filt = '1;
                msk  = '1;
                cmds = '1;
                cnt  = '1;
                pres = '1;
            end
            2: begin
                cnt  = SLOT_CNT_W'(HANDLER_SLOTS);
                pres = '1;
            end
            3: pres = '0;
            default: ;
        endcase
        cfg_write(CFG_ID_FILTER, CFG_DATA_W'(filt));
        cfg_write(CFG_ID_MASK, CFG_DATA_W'(msk));
        cfg_write(CFG_SLOT_COMMANDS, cmds);
        cfg_write(CFG_SLOT_COUNT, CFG_DATA_W'(cnt));
        cfg_write(CFG_SLOT_PRESENT, CFG_DATA_W'(pres));
        if ($urandom_range(0, 1))
            cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, {$urandom, $urandom});
        i_cfg_wr_en <= 1'b0;
    endtask

    // mostly well-formed headers aimed at the registered commands
    task automatic make_frame(output logic [FRAME_ID_W-1:0] id,
                              output logic [FRAME_LEN_W-1:0] len,
                              output logic [CMD_W-1:0] cmd);
        bit                    known;
        int                    lo;
        int                    hi;
        int                    pick;
        int                    k;
        logic [SHORT_ID_W-1:0] low_bits;
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, HANDLER_SLOTS - 1);
        if (pick < 60)
            cmd = sh_cmds[8*k +: 8];
        else if (pick < 85)
            cmd = CMD_W'($urandom_range(FIRST_KNOWN_CMD, LAST_KNOWN_CMD));
        else
            cmd = CMD_W'($urandom_range(0, 255));
        payload_window(cmd, known, lo, hi);
        pick = $urandom_range(0, 99);
        if (known && pick < 70)
            len = FRAME_LEN_W'(lo + 1 + $urandom_range(0, hi - lo));
        else if (known && pick < 80)
            len = FRAME_LEN_W'($urandom_range(0, 1) ? lo : hi + 2);
        else
            len = FRAME_LEN_W'($urandom_range(0, 127));
        low_bits = SHORT_ID_W'($urandom_range(0, 2047));
        if ($urandom_range(0, 99) < 85)
            low_bits = (sh_filter & sh_mask) | (low_bits & ~sh_mask);
        id = FRAME_ID_W'($urandom);
        id[SHORT_ID_W-1:0] = low_bits;
    endtask

    // verdict sink: changing stall patterns plus a long hold-off on request
    initial begin : verdict_sink
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        int       hold_seen;
        int       tick;
        logic     r;
        mode      = RX_STEADY;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        tick      = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                r = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                tick++;
                case (mode)
                    RX_STEADY:      r = 1'b1;
                    RX_COIN:        r = 1'($urandom_range(0, 1));
                    RX_EVERY_THIRD: r = (tick % 3) != 0;
                    default:        r = ($urandom_range(0, 4) == 0);
                endcase
            end
            out_ch.ready <= r;
        end
    end

    // scoreboard: predict on each frame transaction, compare each verdict transaction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (verdicts_due.size() == 0) begin
                    faults++;
                    if (faults <= MAX_REPORTS)
                        $display("tb: verdict v=%0d cmd=%02h with nothing outstanding",
                                 out_ch.verdict, out_ch.command_code);
                end else begin
                    want = verdicts_due.pop_front();
                    verdicts_seen++;
                    vcount[want.verdict]++;
                    if (out_ch.verdict !== want.verdict || out_ch.slot_index !== want.slot_index ||
                        out_ch.command_code !== want.command_code ||
                        out_ch.payload_length !== want.payload_length ||
                        out_ch.short_id !== want.short_id) begin
                        faults++;
                        if (faults <= MAX_REPORTS)
                            $display({"tb: mismatch exp v=%0d slot=%0d cmd=%02h pay=%0d id=%03h",
                                      " got v=%0d slot=%0d cmd=%02h pay=%0d id=%03h"},
                                     want.verdict, want.slot_index, want.command_code,
                                     want.payload_length, want.short_id, out_ch.verdict,
                                     out_ch.slot_index, out_ch.command_code,
                                     out_ch.payload_length, out_ch.short_id);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                want = judge_frame(in_ch.frame_id, in_ch.frame_length, in_ch.first_byte);
                if (pin_on) begin
                    want.verdict    = pin_verdict;
                    want.slot_index = pin_slot;
                end
                verdicts_due.push_back(want);
                frames_taken++;
            end
        end
    end

    // run limit
    initial begin : watchdog
        while (run_cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            run_cycles++;
        end
        $display("tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        t_dir_row               row;
        logic [FRAME_ID_W-1:0]  id;
        logic [FRAME_LEN_W-1:0] len;
        logic [CMD_W-1:0]       cmd;
        bit                     cfg_open;
        in_ch.valid        <= 1'b0;
        in_ch.frame_id     <= '0;
        in_ch.frame_length <= '0;
        in_ch.first_byte   <= '0;
        i_cfg_wr_en        <= 1'b0;
        i_cfg_index        <= '0;
        i_cfg_data         <= '0;
        pin_on             <= 1'b0;
        pin_verdict        <= V_ACCEPT;
        pin_slot           <= '0;
        foreach (vcount[i]) vcount[i] = 0;

        // registers at reset: nothing filtered, no slots in use
        add_frame('0, 7'd0, 8'h00, 1, V_BAD_LENGTH, 0);
        add_frame('1, 7'd127, 8'hFF, 1, V_BAD_LENGTH, 0);
        add_frame(29'h155, 7'd65, CMD_QUAD, 1, V_BAD_LENGTH, 0);
        add_frame(29'h2AA, 7'd1, 8'h00, 1, V_UNKNOWN_CMD, 0);
        add_frame(29'h0AAAAAAA, 7'd64, 8'hFF, 1, V_UNKNOWN_CMD, 0);
        add_frame('0, 7'd2, CMD_PAST_LAST, 1, V_UNKNOWN_CMD, 0);
        add_frame(29'h7FF, 7'd5, CMD_QUAD, 1, V_NO_HANDLER, 0);
        add_frame('0, 7'd1, CMD_EMPTY, 1, V_NO_HANDLER, 0);
        add_frame('0, 7'd2, CMD_EMPTY, 1, V_PAYLOAD_OOB, 0);
        add_frame('0, 7'd12, CMD_LONG, 1, V_PAYLOAD_OOB, 0);
        add_frame('0, 7'd16, CMD_LONG, 1, V_NO_HANDLER, 0);
        add_frame('0, 7'd17, CMD_LONG, 1, V_PAYLOAD_OOB, 0);
        add_frame('0, 7'd12, CMD_ELEVEN, 1, V_NO_HANDLER, 0);
        add_frame('0, 7'd2, LAST_KNOWN_CMD, 1, V_NO_HANDLER, 0);
        // exact filter, count above the slot total, slot one without handler
        add_write(CFG_ID_FILTER, 64'h5A5);
        add_write(CFG_ID_MASK, 64'h7FF);
        add_write(CFG_SLOT_COMMANDS, 64'h13_07_0E_04_0D_01_07_02);
        add_write(CFG_SLOT_COUNT, 64'hF);
        add_write(CFG_SLOT_PRESENT, 64'hFD);
        add_write(CFG_SPARE_A, '1);
        add_write(CFG_SPARE_B, '1);
        add_frame(29'h5A5, 7'd3, CMD_PAIR, 1, V_ACCEPT, 0);
        add_frame(29'h5A4, 7'd3, CMD_PAIR, 1, V_ID_MISMATCH, 0);
        add_frame(29'h1FFFFDA5, 7'd3, CMD_PAIR, 1, V_ACCEPT, 0);
        add_frame(29'h5A5, 7'd2, CMD_SINGLE, 1, V_NO_HANDLER, 0);
        add_frame(29'h5A5, 7'd2, LAST_KNOWN_CMD, 1, V_ACCEPT, 7);
        add_frame(29'h5A5, 7'd12, CMD_ELEVEN, 1, V_ACCEPT, 5);
        add_frame(29'h5A5, 7'd16, CMD_LONG, 0, V_ACCEPT, 0);
        add_frame(29'h5A5, 7'd1, CMD_EMPTY, 0, V_ACCEPT, 0);
        add_frame(29'h5A5, 7'd5, CMD_QUAD_B, 1, V_NO_HANDLER, 0);
        add_frame(29'h5A4, 7'd0, 8'hFF, 1, V_ID_MISMATCH, 0);
        // partial mask, a single slot
        add_write(CFG_ID_FILTER, 64'h7FF);
        add_write(CFG_ID_MASK, 64'h400);
        add_write(CFG_SLOT_COMMANDS, 64'h01_01_01_01_01_01_01_01);
        add_write(CFG_SLOT_COUNT, 64'h1);
        add_write(CFG_SLOT_PRESENT, 64'h01);
        add_frame(29'h400, 7'd5, CMD_QUAD, 0, V_ACCEPT, 0);
        add_frame(29'h3FF, 7'd5, CMD_QUAD, 1, V_ID_MISMATCH, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        cfg_open = 1'b0;
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG) begin
                if (!cfg_open)
                    drain(DRAIN_CYCLES);
                cfg_open = 1'b1;
                cfg_write(row.idx, row.data);
            end else begin
                if (cfg_open) begin
                    i_cfg_wr_en <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_frame(row.id, row.len, row.cmd, row.typed, row.v, row.slot);
            end
        end

        // random phases, each under a fresh register setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain(DRAIN_CYCLES);
            random_config(p);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 2 && n == 30)
                    hold_seq <= hold_seq + 1;
                if (p == 4 && n == 100)
                    drain(1);
                make_frame(id, len, cmd);
                send_frame(id, len, cmd, 1'b0, V_ACCEPT, '0);
            end
        end
        drain(DRAIN_CYCLES);

        $display("tb: %0d frame headers judged over %0d register writes, %0d mismatches",
                 frames_taken, cfg_writes, faults);
        $display({"tb: verdicts accept %0d, id %0d, length %0d,",
                  " command %0d, bounds %0d, handler %0d"},
                 vcount[V_ACCEPT], vcount[V_ID_MISMATCH], vcount[V_BAD_LENGTH],
                 vcount[V_UNKNOWN_CMD], vcount[V_PAYLOAD_OOB], vcount[V_NO_HANDLER]);
        if (faults == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
